### rtl/core/mse_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MIPS32 subset execute block.
// Depends on nothing; the interfaces, divider, controller, datapath and top level import it.
package mse_pkg;

    localparam int unsigned XLEN           = 32;
    localparam int unsigned REGISTER_COUNT = 32;
    localparam int unsigned REG_IDX_W      = $clog2(REGISTER_COUNT);
    localparam int unsigned PADDR_W        = 3;

    localparam logic [REG_IDX_W-1:0] REG_SP   = REG_IDX_W'(29);
    localparam logic [REG_IDX_W-1:0] REG_RA   = REG_IDX_W'(31);
    localparam logic [REG_IDX_W-1:0] REG_ZERO = REG_IDX_W'(0);

    localparam logic [XLEN-1:0] ENTRY_PC_RESET  = 32'h0040_0000;
    localparam logic [XLEN-1:0] STACK_TOP_RESET = 32'h0000_0000;
    localparam logic [XLEN-1:0] REGION_MASK     = 32'hF000_0000;

    localparam logic CFG_ENTRY_PC  = 1'b0;
    localparam logic CFG_STACK_TOP = 1'b1;

    localparam logic MODE_INSTR = 1'b0;
    localparam logic MODE_LOAD  = 1'b1;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_SPECIAL2 = 6'h1C;
    localparam logic [5:0] OP_SPECIAL3 = 6'h1F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;
    localparam logic [5:0] FN_MUL     = 6'h02;
    localparam logic [5:0] FN_BSHFL   = 6'h20;

    localparam logic [4:0] RT_BLTZ   = 5'h00;
    localparam logic [4:0] RT_BGEZ   = 5'h01;
    localparam logic [4:0] RT_BLTZAL = 5'h10;
    localparam logic [4:0] RT_BGEZAL = 5'h11;

    localparam logic [4:0] SA_SEB = 5'h10;
    localparam logic [4:0] SA_SEH = 5'h18;

    localparam logic [1:0] MREQ_NONE  = 2'd0;
    localparam logic [1:0] MREQ_LOAD  = 2'd1;
    localparam logic [1:0] MREQ_STORE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [1:0] TRAP_NONE    = 2'd0;
    localparam logic [1:0] TRAP_SYSCALL = 2'd1;
    localparam logic [1:0] TRAP_ILLEGAL = 2'd2;

    typedef enum logic [2:0] {
        LK_NONE = 3'd0,
        LK_LB   = 3'd1,
        LK_LH   = 3'd2,
        LK_LW   = 3'd3,
        LK_LBU  = 3'd4,
        LK_LHU  = 3'd5
    } load_kind_t;

    typedef struct packed {
        logic accept;
        logic commit;
        logic div_start;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_req;
        logic div_done;
    } dp_status_t;

endpackage

### rtl/core/mse_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instruction words and result words.
// Depends on mse_pkg for the data width.
interface mse_item_if;
    import mse_pkg::*;
    logic            valid;
    logic            ready;
    logic            mode;
    logic [XLEN-1:0] instr_word;
    logic [XLEN-1:0] load_data;

    modport source (output valid, mode, instr_word, load_data, input ready);
    modport sink (input valid, mode, instr_word, load_data, output ready);
endinterface

interface mse_result_if;
    import mse_pkg::*;
    logic            valid;
    logic            ready;
    logic [XLEN-1:0] fetch_pc;
    logic [1:0]      mem_req;
    logic [XLEN-1:0] mem_addr;
    logic [1:0]      mem_size;
    logic [XLEN-1:0] store_data;
    logic [1:0]      trap;

    modport source (output valid, fetch_pc, mem_req, mem_addr, mem_size, store_data, trap,
                    input ready);
    modport sink (input valid, fetch_pc, mem_req, mem_addr, mem_size, store_data, trap,
                  output ready);
endinterface

### rtl/core/mse_ram.sv
`timescale 1ns / 1ps
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
module mse_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

### rtl/core/mse_divider.sv
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle, signed or unsigned.
// Depends on mse_pkg.
module mse_divider (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     is_signed,
    input  logic [mse_pkg::XLEN-1:0] dividend,
    input  logic [mse_pkg::XLEN-1:0] divisor,
    output logic                     done,
    output logic [mse_pkg::XLEN-1:0] quotient,
    output logic [mse_pkg::XLEN-1:0] remainder
);
    import mse_pkg::*;

    localparam int unsigned CNT_W = $clog2(XLEN);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [XLEN-1:0] q_reg, q_next;
    logic [XLEN-1:0] r_reg, r_next;
    logic [XLEN-1:0] d_reg, d_next;
    logic            negq_reg, negq_next;
    logic            negr_reg, negr_next;
    logic [XLEN:0]   trial;
    logic            na, nb;

    always_comb
    begin
        na = is_signed & dividend[XLEN-1];
        nb = is_signed & divisor[XLEN-1];
        trial = {r_reg, q_reg[XLEN-1]} - {1'b0, d_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            q_next = na ? (XLEN'(0) - dividend) : dividend;
            d_next = nb ? (XLEN'(0) - divisor) : divisor;
            r_next = '0;
            negq_next = na ^ nb;
            negr_next = na;
        end
        else if (busy_reg)
        begin
            if (!trial[XLEN])
            begin
                r_next = trial[XLEN-1:0];
                q_next = {q_reg[XLEN-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[XLEN-2:0], q_reg[XLEN-1]};
                q_next = {q_reg[XLEN-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(XLEN - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    assign done = done_reg;
    assign quotient = negq_reg ? (XLEN'(0) - q_reg) : q_reg;
    assign remainder = negr_reg ? (XLEN'(0) - r_reg) : r_reg;
endmodule

### rtl/core/mse_controller.sv
`timescale 1ns / 1ps
// Sequencer: accepts a word, commits it when the result register is free,
// and waits out the divider. Depends on mse_pkg.
module mse_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  mse_pkg::dp_status_t    status,
    output mse_pkg::ctrl_cmd_t     cmd
);
    import mse_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    out_valid_next = 1'b1;
                    if (status.div_req)
                    begin
                        cmd.div_start = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
endmodule

### rtl/core/mse_datapath.sv
`timescale 1ns / 1ps
// Datapath: register file, HI/LO, program counter, execute logic, result
// register and configuration registers. Depends on mse_pkg, mse_ram, mse_divider.
module mse_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mse_pkg::ctrl_cmd_t          cmd,
    output mse_pkg::dp_status_t         status,
    input  logic                        in_mode,
    input  logic [mse_pkg::XLEN-1:0]    in_instr_word,
    input  logic [mse_pkg::XLEN-1:0]    in_load_data,
    output logic [mse_pkg::XLEN-1:0]    fetch_pc,
    output logic [1:0]                  mem_req,
    output logic [mse_pkg::XLEN-1:0]    mem_addr,
    output logic [1:0]                  mem_size,
    output logic [mse_pkg::XLEN-1:0]    store_data,
    output logic [1:0]                  trap,
    input  logic                        cfg_we,
    input  logic [mse_pkg::PADDR_W-1:0] cfg_addr,
    input  logic [mse_pkg::XLEN-1:0]    cfg_wdata,
    output logic [mse_pkg::XLEN-1:0]    cfg_rdata
);
    import mse_pkg::*;

    logic [XLEN-1:0] entry_pc_reg, stack_top_reg;
    logic [XLEN-1:0] pc_reg, pc_next;
    logic [XLEN-1:0] hi_reg, hi_next;
    logic [XLEN-1:0] lo_reg, lo_next;
    logic            pend_reg, pend_next;
    logic [XLEN-1:0] btgt_reg, btgt_next;
    logic [REG_IDX_W-1:0] ldst_reg, ldst_next;
    load_kind_t      lkind_reg, lkind_next;
    logic [REGISTER_COUNT-1:0] rf_valid_reg;

    logic            mode_reg;
    logic [XLEN-1:0] instr_reg;
    logic [XLEN-1:0] ldata_reg;

    logic [XLEN-1:0] res_pc_reg, res_addr_reg, res_sdata_reg;
    logic [1:0]      res_req_reg, res_size_reg, res_trap_reg;

    logic [XLEN-1:0] ram_a, ram_b, a, b;
    logic [5:0]      op, fn;
    logic [4:0]      rs, rt, rd, sa, sh;
    logic [XLEN-1:0] simm, uimm, pc4, link, brt;
    logic [2*XLEN+1:0] prod;
    logic            sgn_mul;

    logic            wb_en;
    logic [REG_IDX_W-1:0] wb_idx;
    logic [XLEN-1:0] wb_val;
    logic            cti, taken, lk;
    logic [XLEN-1:0] tgt;
    logic [1:0]      o_req, o_size, o_trap;
    logic [XLEN-1:0] o_addr, o_sdata;

    logic            rf_we;
    logic [REG_IDX_W-1:0] rf_waddr;
    logic [XLEN-1:0] rf_wdata;

    logic            div_done;
    logic [XLEN-1:0] div_q, div_r;

    assign op = instr_reg[31:26];
    assign rs = instr_reg[25:21];
    assign rt = instr_reg[20:16];
    assign rd = instr_reg[15:11];
    assign sa = instr_reg[10:6];
    assign fn = instr_reg[5:0];

    mse_ram #(
        .WIDTH (XLEN),
        .DEPTH (REGISTER_COUNT)
    ) u_rf (
        .clk     (clk),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .raddr_a (cmd.accept ? in_instr_word[25:21] : rs),
        .raddr_b (cmd.accept ? in_instr_word[20:16] : rt),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    mse_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .is_signed (fn == FN_DIV),
        .dividend  (a),
        .divisor   (b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        a = rf_valid_reg[rs] ? ram_a : '0;
        b = rf_valid_reg[rt] ? ram_b : '0;
        simm = {{16{instr_reg[15]}}, instr_reg[15:0]};
        uimm = {16'h0000, instr_reg[15:0]};
        pc4 = pc_reg + XLEN'(4);
        link = pc_reg + XLEN'(8);
        brt = pc4 + {simm[XLEN-3:0], 2'b00};
        sh = (fn == FN_SLLV || fn == FN_SRLV || fn == FN_SRAV) ? a[4:0] : sa;
        sgn_mul = (op == OP_SPECIAL) && (fn == FN_MULT);
        prod = $signed({sgn_mul & a[XLEN-1], a}) * $signed({sgn_mul & b[XLEN-1], b});

        wb_en = 1'b0;
        wb_idx = rd;
        wb_val = '0;
        cti = 1'b0;
        taken = 1'b0;
        lk = 1'b0;
        tgt = brt;
        o_req = MREQ_NONE;
        o_size = SIZE_BYTE;
        o_addr = '0;
        o_sdata = '0;
        o_trap = TRAP_NONE;
        hi_next = hi_reg;
        lo_next = lo_reg;
        ldst_next = ldst_reg;
        lkind_next = LK_NONE;
        pc_next = pc_reg;
        pend_next = pend_reg;
        btgt_next = btgt_reg;
        status.div_req = 1'b0;

        if (mode_reg == MODE_LOAD)
        begin
            wb_idx = ldst_reg;
            wb_en = 1'b1;
            case (lkind_reg)
                LK_LB:   wb_val = {{24{ldata_reg[7]}}, ldata_reg[7:0]};
                LK_LH:   wb_val = {{16{ldata_reg[15]}}, ldata_reg[15:0]};
                LK_LW:   wb_val = ldata_reg;
                LK_LBU:  wb_val = {24'h000000, ldata_reg[7:0]};
                LK_LHU:  wb_val = {16'h0000, ldata_reg[15:0]};
                default: wb_en = 1'b0;
            endcase
        end
        else
        begin
            unique case (op)
                OP_SPECIAL:
                begin
                    wb_en = 1'b1;
                    case (fn)
                        FN_SLL, FN_SLLV: wb_val = b << sh;
                        FN_SRL, FN_SRLV: wb_val = b >> sh;
                        FN_SRA, FN_SRAV: wb_val = XLEN'($signed(b) >>> sh);
                        FN_JR:
                        begin
                            wb_en = 1'b0;
                            cti = 1'b1;
                            taken = 1'b1;
                            tgt = a;
                        end
                        FN_JALR:
                        begin
                            cti = 1'b1;
                            taken = 1'b1;
                            tgt = a;
                            wb_val = link;
                        end
                        FN_SYSCALL:
                        begin
                            wb_en = 1'b0;
                            o_trap = TRAP_SYSCALL;
                        end
                        FN_MFHI: wb_val = hi_reg;
                        FN_MFLO: wb_val = lo_reg;
                        FN_MTHI:
                        begin
                            wb_en = 1'b0;
                            hi_next = a;
                        end
                        FN_MTLO:
                        begin
                            wb_en = 1'b0;
                            lo_next = a;
                        end
                        FN_MULT, FN_MULTU:
                        begin
                            wb_en = 1'b0;
                            hi_next = prod[2*XLEN-1:XLEN];
                            lo_next = prod[XLEN-1:0];
                        end
                        FN_DIV, FN_DIVU:
                        begin
                            wb_en = 1'b0;
                            status.div_req = (b != '0);
                        end
                        FN_ADD, FN_ADDU: wb_val = a + b;
                        FN_SUB, FN_SUBU: wb_val = a - b;
                        FN_AND:  wb_val = a & b;
                        FN_OR:   wb_val = a | b;
                        FN_XOR:  wb_val = a ^ b;
                        FN_NOR:  wb_val = ~(a | b);
                        FN_SLT:  wb_val = {31'd0, $signed(a) < $signed(b)};
                        FN_SLTU: wb_val = {31'd0, a < b};
                        default:
                        begin
                            wb_en = 1'b0;
                            o_trap = TRAP_ILLEGAL;
                        end
                    endcase
                end
                OP_REGIMM:
                begin
                    case (rt)
                        RT_BLTZ:
                        begin
                            cti = 1'b1;
                            taken = a[XLEN-1];
                        end
                        RT_BGEZ:
                        begin
                            cti = 1'b1;
                            taken = !a[XLEN-1];
                        end
                        RT_BLTZAL:
                        begin
                            cti = 1'b1;
                            taken = a[XLEN-1];
                            lk = 1'b1;
                        end
                        RT_BGEZAL:
                        begin
                            cti = 1'b1;
                            taken = !a[XLEN-1];
                            lk = 1'b1;
                        end
                        default: o_trap = TRAP_ILLEGAL;
                    endcase
                    wb_en = lk;
                    wb_idx = REG_RA;
                    wb_val = link;
                end
                OP_J, OP_JAL:
                begin
                    cti = 1'b1;
                    taken = 1'b1;
                    tgt = (pc4 & REGION_MASK) | {4'h0, instr_reg[25:0], 2'b00};
                    wb_en = (op == OP_JAL);
                    wb_idx = REG_RA;
                    wb_val = link;
                end
                OP_BEQ:
                begin
                    cti = 1'b1;
                    taken = (a == b);
                end
                OP_BNE:
                begin
                    cti = 1'b1;
                    taken = (a != b);
                end
                OP_BLEZ:
                begin
                    cti = 1'b1;
                    taken = (a == '0) || a[XLEN-1];
                end
                OP_BGTZ:
                begin
                    cti = 1'b1;
                    taken = (a != '0) && !a[XLEN-1];
                end
                OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI:
                begin
                    wb_en = 1'b1;
                    wb_idx = rt;
                    case (op)
                        OP_SLTI:  wb_val = {31'd0, $signed(a) < $signed(simm)};
                        OP_SLTIU: wb_val = {31'd0, a < simm};
                        OP_ANDI:  wb_val = a & uimm;
                        OP_ORI:   wb_val = a | uimm;
                        OP_XORI:  wb_val = a ^ uimm;
                        OP_LUI:   wb_val = {instr_reg[15:0], 16'h0000};
                        default:  wb_val = a + simm;
                    endcase
                end
                OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU:
                begin
                    o_req = MREQ_LOAD;
                    o_addr = a + simm;
                    ldst_next = rt;
                    case (op)
                        OP_LB:
                        begin
                            o_size = SIZE_BYTE;
                            lkind_next = LK_LB;
                        end
                        OP_LBU:
                        begin
                            o_size = SIZE_BYTE;
                            lkind_next = LK_LBU;
                        end
                        OP_LW:
                        begin
                            o_size = SIZE_WORD;
                            lkind_next = LK_LW;
                        end
                        OP_LH:
                        begin
                            o_size = SIZE_HALF;
                            lkind_next = LK_LH;
                        end
                        default:
                        begin
                            o_size = SIZE_HALF;
                            lkind_next = LK_LHU;
                        end
                    endcase
                end
                OP_SB, OP_SH, OP_SW:
                begin
                    o_req = MREQ_STORE;
                    o_addr = a + simm;
                    case (op)
                        OP_SB:
                        begin
                            o_size = SIZE_BYTE;
                            o_sdata = {24'h000000, b[7:0]};
                        end
                        OP_SH:
                        begin
                            o_size = SIZE_HALF;
                            o_sdata = {16'h0000, b[15:0]};
                        end
                        default:
                        begin
                            o_size = SIZE_WORD;
                            o_sdata = b;
                        end
                    endcase
                end
                OP_SPECIAL2:
                begin
                    if (fn == FN_MUL)
                    begin
                        wb_en = 1'b1;
                        wb_val = prod[XLEN-1:0];
                    end
                    else
                    begin
                        o_trap = TRAP_ILLEGAL;
                    end
                end
                OP_SPECIAL3:
                begin
                    if (fn == FN_BSHFL && sa == SA_SEB)
                    begin
                        wb_en = 1'b1;
                        wb_val = {{24{b[7]}}, b[7:0]};
                    end
                    else if (fn == FN_BSHFL && sa == SA_SEH)
                    begin
                        wb_en = 1'b1;
                        wb_val = {{16{b[15]}}, b[15:0]};
                    end
                    else
                    begin
                        o_trap = TRAP_ILLEGAL;
                    end
                end
                default: o_trap = TRAP_ILLEGAL;
            endcase

            if (cti)
            begin
                if (taken)
                begin
                    pend_next = 1'b1;
                    btgt_next = tgt;
                end
                pc_next = pc4;
            end
            else if (pend_reg)
            begin
                pc_next = btgt_reg;
                pend_next = 1'b0;
            end
            else
            begin
                pc_next = pc4;
            end
        end

        status.div_done = div_done;

        if (cfg_we && cfg_addr[2] == CFG_STACK_TOP)
        begin
            rf_we = 1'b1;
            rf_waddr = REG_SP;
            rf_wdata = cfg_wdata;
        end
        else
        begin
            rf_we = cmd.commit && wb_en && (wb_idx != REG_ZERO);
            rf_waddr = wb_idx;
            rf_wdata = wb_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_pc_reg <= ENTRY_PC_RESET;
            stack_top_reg <= STACK_TOP_RESET;
            pc_reg <= ENTRY_PC_RESET;
            hi_reg <= '0;
            lo_reg <= '0;
            pend_reg <= 1'b0;
            btgt_reg <= '0;
            ldst_reg <= '0;
            lkind_reg <= LK_NONE;
            rf_valid_reg <= '0;
        end
        else
        begin
            if (rf_we)
            begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
            if (cfg_we && cfg_addr[2] == CFG_ENTRY_PC)
            begin
                entry_pc_reg <= cfg_wdata;
                pc_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_addr[2] == CFG_STACK_TOP)
            begin
                stack_top_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                pc_reg <= pc_next;
                hi_reg <= hi_next;
                lo_reg <= lo_next;
                pend_reg <= pend_next;
                btgt_reg <= btgt_next;
                ldst_reg <= ldst_next;
                lkind_reg <= lkind_next;
            end
            if (div_done)
            begin
                hi_reg <= div_r;
                lo_reg <= div_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= in_mode;
            instr_reg <= in_instr_word;
            ldata_reg <= in_load_data;
        end
        if (cmd.commit)
        begin
            res_pc_reg <= pc_next;
            res_req_reg <= o_req;
            res_addr_reg <= o_addr;
            res_size_reg <= o_size;
            res_sdata_reg <= o_sdata;
            res_trap_reg <= o_trap;
        end
    end

    assign fetch_pc = res_pc_reg;
    assign mem_req = res_req_reg;
    assign mem_addr = res_addr_reg;
    assign mem_size = res_size_reg;
    assign store_data = res_sdata_reg;
    assign trap = res_trap_reg;
    assign cfg_rdata = (cfg_addr[2] == CFG_STACK_TOP) ? stack_top_reg : entry_pc_reg;
endmodule

### rtl/core/mips32_subset_execute.sv
`timescale 1ns / 1ps
// A word is accepted in IDLE, which issues its register file read, and executes in EXEC;
// EXEC commits it with writeback once the result register is free or being taken; only then
// can a word enter; div/divu with a nonzero divisor hold it off until the divider is done.
// The result register lets the next word enter while a result waits to be taken. Reset is
// asynchronous and active low and restores control and register state without a clearing pass.
module mips32_subset_execute (
    input  logic                        clk,
    input  logic                        rst_n,
    mse_item_if.sink                    item,
    mse_result_if.source                result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mse_pkg::PADDR_W-1:0] paddr,
    input  logic [mse_pkg::XLEN-1:0]    pwdata,
    output logic [mse_pkg::XLEN-1:0]    prdata,
    output logic                        pready
);
    import mse_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign pready = 1'b1;

    mse_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mse_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_mode       (item.mode),
        .in_instr_word (item.instr_word),
        .in_load_data  (item.load_data),
        .fetch_pc      (result.fetch_pc),
        .mem_req       (result.mem_req),
        .mem_addr      (result.mem_addr),
        .mem_size      (result.mem_size),
        .store_data    (result.store_data),
        .trap          (result.trap),
        .cfg_we        (psel && penable && pwrite && pready),
        .cfg_addr      (paddr),
        .cfg_wdata     (pwdata),
        .cfg_rdata     (prdata)
    );
endmodule

### rtl/core/mse_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the execute block, bound to its top level.
// Depends on mips32_subset_execute.
module mse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  mem_req,
    input logic [1:0]  mem_size,
    input logic [31:0] mem_addr,
    input logic [31:0] store_data,
    input logic [1:0]  trap
);
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("word accepted while a word was in flight");

    a_codes_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mem_req != 2'd3 && trap != 2'd3 && mem_size != 2'd3))
        else $error("result carries an undefined code");

    a_no_mem_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mem_req == 2'd0) |-> (mem_addr == 32'd0 && mem_size == 2'd0))
        else $error("address fields set without a memory request");

    a_store_data_only_store: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mem_req != 2'd2) |-> (store_data == 32'd0))
        else $error("store data set on a word that is not a store");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(mem_addr) && $stable(trap)))
        else $error("stalled result changed");
endmodule

bind mips32_subset_execute mse_checker u_mse_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .mem_req    (result.mem_req),
    .mem_size   (result.mem_size),
    .mem_addr   (result.mem_addr),
    .store_data (result.store_data),
    .trap       (result.trap)
);
